[rtl/pwpt_pkg.sv]
// ----------------------------------------------------------------------------
// pwpt_pkg: shared types and constants of the polygon winding point test
// Holds the verdict codes, the parser phases and the records that pass
// between the byte parser and the geometry unit.
// ----------------------------------------------------------------------------
package pwpt_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1000000;
  localparam int unsigned CoordW = 32;
  localparam int unsigned VerdictW = 3;

  localparam logic [VerdictW-1:0] V_OUTSIDE = 3'd0;
  localparam logic [VerdictW-1:0] V_IN_ZONE = 3'd1;
  localparam logic [VerdictW-1:0] V_EXCLUDED = 3'd2;
  localparam logic [VerdictW-1:0] V_ON_VERTEX = 3'd3;
  localparam logic [VerdictW-1:0] V_ON_SEGMENT = 3'd4;
  localparam logic [VerdictW-1:0] V_PARSE_ERROR = 3'd5;

  // Register indexes of the configuration port.
  localparam logic REG_TARGET_LAT = 1'b0;
  localparam logic REG_TARGET_LON = 1'b1;

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_LAT   = 2'd1,
    PH_LON   = 2'd2,
    PH_BAD   = 2'd3
  } phase_e;

  // One geometry command: visit a point, optionally the closing point after it,
  // and optionally produce the final winding verdict.
  typedef struct packed {
    logic [CoordW-1:0] lat;
    logic [CoordW-1:0] lon;
    logic              has_prev;
    logic              close;
    logic [CoordW-1:0] clat;
    logic [CoordW-1:0] clon;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [VerdictW-1:0] verdict;
  } resp_t;

  typedef struct packed {
    logic busy;
    logic decided;
  } front_stat_t;

endpackage

[rtl/pwpt_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// pwpt_cmd_fifo: two-entry command queue
// Decouples the byte parser from the geometry unit.
// ----------------------------------------------------------------------------
module pwpt_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pwpt_pkg::cmd_t push_data_i,
  input  logic           pop_i,
  output pwpt_pkg::cmd_t head_o,
  output logic           not_empty_o,
  output logic           full_o
);
  import pwpt_pkg::*;

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign not_empty_o = (count_q != 2'd0);
  assign full_o      = (count_q == 2'd2);
  assign head_o      = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wptr_q <= ~wptr_q;
      if (pop_i && not_empty_o) rptr_q <= ~rptr_q;
      count_q <= count_q + {1'b0, (push_i && !full_o)} - {1'b0, (pop_i && not_empty_o)};
    end
  end

endmodule

[rtl/pwpt_front.sv]
// ----------------------------------------------------------------------------
// pwpt_front: record byte parser
// Decodes varints, accumulates vertices, issues geometry commands and owns the
// verdict output register.
// ----------------------------------------------------------------------------
module pwpt_front #(
  parameter int unsigned MaxVertices = pwpt_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          record_start_i,
  input  logic                          buffer_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pwpt_pkg::VerdictW-1:0] verdict_o,
  output logic                          cmd_push_o,
  output pwpt_pkg::cmd_t                cmd_o,
  input  pwpt_pkg::resp_t               resp_i,
  output pwpt_pkg::front_stat_t         stat_o
);
  import pwpt_pkg::*;

  localparam int unsigned CntW = $clog2(MaxVertices + 1);

  logic [CoordW-1:0]   acc_q, acc_d;
  logic [5:0]          shift_q, shift_d;
  phase_e              phase_q, phase_d;
  logic [CntW-1:0]     vtot_q, vtot_d, vdone_q, vdone_d;
  logic [CoordW-1:0]   plat_q, plat_d, plon_q, plon_d, flat_q, flat_d, flon_q, flon_d;
  logic                decided_q, decided_d;
  logic                wait_q, wait_d;
  logic                last_q, last_d;
  logic                ovalid_q, ovalid_d;
  logic [VerdictW-1:0] verdict_q, verdict_d;
  logic                fire, issue, err;
  logic [CoordW-1:0]   v;
  cmd_t                cmd;

  function automatic logic [CoordW-1:0] unzig(input logic [CoordW-1:0] x);
    unzig = x[0] ? (CoordW'(0) - (x >> 1)) : (x >> 1);
  endfunction

  assign in_stall_o  = wait_q || (ovalid_q && out_stall_i);
  assign fire        = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;
  assign verdict_o   = verdict_q;
  assign cmd_push_o  = issue;
  assign cmd_o       = cmd;
  assign stat_o      = '{busy: wait_q, decided: decided_q};

  always_comb begin
    acc_d     = acc_q;
    shift_d   = shift_q;
    phase_d   = phase_q;
    vtot_d    = vtot_q;
    vdone_d   = vdone_q;
    plat_d    = plat_q;
    plon_d    = plon_q;
    flat_d    = flat_q;
    flon_d    = flon_q;
    decided_d = decided_q;
    wait_d    = wait_q;
    last_d    = last_q;
    ovalid_d  = ovalid_q && out_stall_i;
    verdict_d = verdict_q;
    issue     = 1'b0;
    err       = 1'b0;
    v         = '0;
    cmd       = '0;
    if (fire) begin
      if (record_start_i) begin
        acc_d     = '0;
        shift_d   = '0;
        phase_d   = PH_COUNT;
        vtot_d    = '0;
        vdone_d   = '0;
        plat_d    = '0;
        plon_d    = '0;
        flat_d    = '0;
        flon_d    = '0;
        decided_d = 1'b0;
      end
      if (!decided_d) begin
        if (shift_d < 6'd32) begin
          acc_d   = acc_d | ({25'd0, data_byte_i[6:0]} << shift_d);
          shift_d = shift_d + 6'd7;
        end
        if (!data_byte_i[7]) begin
          v       = acc_d;
          acc_d   = '0;
          shift_d = '0;
          case (phase_d)
            PH_COUNT: begin
              if (v > CoordW'(MaxVertices)) begin
                err = 1'b1;
              end else begin
                vtot_d = v[CntW-1:0];
                if (v == '0) begin
                  issue        = 1'b1;
                  cmd.lat      = flat_d;
                  cmd.lon      = flon_d;
                  cmd.finish   = 1'b1;
                end else begin
                  phase_d = PH_LAT;
                end
              end
            end
            PH_LAT: begin
              plat_d  = plat_d + unzig(v);
              phase_d = PH_LON;
            end
            PH_LON: begin
              plon_d       = plon_d + unzig(v);
              phase_d      = PH_LAT;
              issue        = 1'b1;
              cmd.lat      = plat_d;
              cmd.lon      = plon_d;
              cmd.has_prev = (vdone_d != '0);
              cmd.close    = ({1'b0, vdone_d} + 1'b1) >= {1'b0, vtot_d};
              cmd.finish   = cmd.close;
              if (vdone_d == '0) begin
                flat_d = plat_d;
                flon_d = plon_d;
              end
              cmd.clat = flat_d;
              cmd.clon = flon_d;
              vdone_d  = vdone_d + 1'b1;
            end
            default: err = 1'b1;
          endcase
        end
        if (issue) begin
          wait_d = 1'b1;
          last_d = buffer_last_i;
        end else if (err || buffer_last_i) begin
          ovalid_d  = 1'b1;
          verdict_d = V_PARSE_ERROR;
          decided_d = 1'b1;
        end
      end
    end
    if (wait_q && resp_i.valid) begin
      wait_d = 1'b0;
      if (resp_i.hit) begin
        ovalid_d  = 1'b1;
        verdict_d = resp_i.verdict;
        decided_d = 1'b1;
      end else if (last_q) begin
        ovalid_d  = 1'b1;
        verdict_d = V_PARSE_ERROR;
        decided_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      shift_q   <= '0;
      phase_q   <= PH_COUNT;
      vtot_q    <= '0;
      vdone_q   <= '0;
      plat_q    <= '0;
      plon_q    <= '0;
      flat_q    <= '0;
      flon_q    <= '0;
      decided_q <= 1'b1;
      wait_q    <= 1'b0;
      last_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      shift_q   <= shift_d;
      phase_q   <= phase_d;
      vtot_q    <= vtot_d;
      vdone_q   <= vdone_d;
      plat_q    <= plat_d;
      plon_q    <= plon_d;
      flat_q    <= flat_d;
      flon_q    <= flon_d;
      decided_q <= decided_d;
      wait_q    <= wait_d;
      last_q    <= last_d;
      ovalid_q  <= ovalid_d;
    end
  end

endmodule

[rtl/pwpt_back.sv]
// ----------------------------------------------------------------------------
// pwpt_back: quadrant and winding unit
// Visits points against the target, keeps the winding sum and resolves
// diagonal quadrant jumps with a shared shift-add multiplier.
// ----------------------------------------------------------------------------
module pwpt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pwpt_pkg::CoordW-1:0] target_lat_i,
  input  logic [pwpt_pkg::CoordW-1:0] target_lon_i,
  input  logic                        cmd_avail_i,
  input  pwpt_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output pwpt_pkg::resp_t             resp_o
);
  import pwpt_pkg::*;

  typedef enum logic [4:0] {
    B_IDLE  = 5'b00001,
    B_VISIT = 5'b00010,
    B_MUL   = 5'b00100,
    B_DIAG  = 5'b01000,
    B_NEXT  = 5'b10000
  } bstate_e;

  bstate_e            st_q, st_d;
  cmd_t               cmd_q, cmd_d;
  logic               second_q, second_d;
  logic [CoordW-1:0]  prev_lat_q, prev_lat_d, prev_lon_q, prev_lon_d;
  logic [1:0]         prevq_q, prevq_d, newq_q, newq_d;
  logic [CoordW-1:0]  wsum_q, wsum_d;
  logic               nn_q, nn_d;
  logic signed [32:0] c_q, c_d;
  logic [32:0]        md_q, md_d;
  logic [1:0]         idx_q, idx_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [67:0]        macc_q, macc_d, ma_q, ma_d, macc_nx;
  logic [33:0]        mb_q, mb_d;
  logic [67:0]        prod_q [4];
  logic [67:0]        prod_d [4];
  resp_t              resp_q, resp_d;

  logic [CoordW-1:0]  tn, cur_lat, cur_lon;
  logic               has_prev, hit, q_adj_up, q_adj_dn, less, eq;
  logic [1:0]         q;
  logic signed [33:0] cp1, c0, cm1, e_s, dlat_s, dlon_s;
  logic [33:0]        op_a;
  logic signed [1:0]  s_m1, s_0, s_p1;

  function automatic logic [33:0] mag34(input logic signed [33:0] x);
    mag34 = x[33] ? (34'd0 - x) : x;
  endfunction

  // Sign of a signed sum given as two sign/magnitude terms.
  function automatic logic signed [1:0] sum_sign(input logic na, input logic [67:0] ma,
                                                 input logic nb, input logic [67:0] mb);
    logic signed [1:0] r;
    if (ma == '0 && mb == '0) r = 2'sd0;
    else if (ma == '0) r = nb ? -2'sd1 : 2'sd1;
    else if (mb == '0) r = na ? -2'sd1 : 2'sd1;
    else if (na == nb) r = na ? -2'sd1 : 2'sd1;
    else if (ma == mb) r = 2'sd0;
    else if (ma > mb) r = na ? -2'sd1 : 2'sd1;
    else r = nb ? -2'sd1 : 2'sd1;
    return r;
  endfunction

  function automatic logic [VerdictW-1:0] final_verdict(input logic [CoordW-1:0] w);
    if (w == 32'hFFFF_FFFC) final_verdict = V_IN_ZONE;
    else if (w == 32'd4) final_verdict = V_EXCLUDED;
    else if (w == 32'd0) final_verdict = V_OUTSIDE;
    else final_verdict = V_ON_SEGMENT;
  endfunction

  assign tn       = target_lon_i - 32'd3;
  assign cur_lat  = second_q ? cmd_q.clat : cmd_q.lat;
  assign cur_lon  = second_q ? cmd_q.clon : cmd_q.lon;
  assign has_prev = second_q || cmd_q.has_prev;
  assign hit      = (cur_lat == target_lat_i) && (cur_lon == tn);
  assign q = ($signed(cur_lat) >= $signed(target_lat_i))
             ? (($signed(cur_lon) >= $signed(tn)) ? 2'd0 : 2'd1)
             : (($signed(cur_lon) >= $signed(tn)) ? 2'd3 : 2'd2);
  assign q_adj_up = (q == prevq_q + 2'd1);
  assign q_adj_dn = (q + 2'd1 == prevq_q);

  assign e_s    = {{2{target_lat_i[31]}}, target_lat_i} - {{2{cur_lat[31]}}, cur_lat};
  assign dlat_s = {{2{cur_lat[31]}}, cur_lat} - {{2{prev_lat_q[31]}}, prev_lat_q};
  assign dlon_s = {{2{cur_lon[31]}}, cur_lon} - {{2{prev_lon_q[31]}}, prev_lon_q};

  assign c0  = {c_q[32], c_q};
  assign cp1 = c0 + 34'sd1;
  assign cm1 = c0 - 34'sd1;

  // Multiplicand of the pass that follows the one now finishing.
  always_comb begin
    case (idx_q)
      2'd0:    op_a = mag34(cp1);
      2'd1:    op_a = mag34(c0);
      default: op_a = mag34(cm1);
    endcase
  end

  assign macc_nx = mb_q[0] ? (macc_q + ma_q) : macc_q;

  assign s_m1 = sum_sign(cp1[33], prod_q[1], nn_q, prod_q[0]);
  assign s_0  = sum_sign(c0[33], prod_q[2], nn_q, prod_q[0]);
  assign s_p1 = sum_sign(cm1[33], prod_q[3], nn_q, prod_q[0]);

  always_comb begin
    if (!tn[31] && tn != '0) begin
      eq   = (s_0 >= 2'sd0) && (s_p1 < 2'sd0);
      less = (s_0 < 2'sd0);
    end else if (tn == '0) begin
      eq   = (s_m1 > 2'sd0) && (s_p1 < 2'sd0);
      less = (s_m1 <= 2'sd0);
    end else begin
      eq   = (s_m1 > 2'sd0) && (s_0 <= 2'sd0);
      less = (s_m1 <= 2'sd0);
    end
  end

  assign cmd_pop_o = (st_q == B_IDLE) && cmd_avail_i;
  assign resp_o    = resp_q;

  always_comb begin
    st_d       = st_q;
    cmd_d      = cmd_q;
    second_d   = second_q;
    prev_lat_d = prev_lat_q;
    prev_lon_d = prev_lon_q;
    prevq_d    = prevq_q;
    newq_d     = newq_q;
    wsum_d     = wsum_q;
    nn_d       = nn_q;
    c_d        = c_q;
    md_d       = md_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    macc_d     = macc_q;
    ma_d       = ma_q;
    mb_d       = mb_q;
    prod_d     = prod_q;
    resp_d     = '0;
    case (st_q)
      B_IDLE: begin
        if (cmd_avail_i) begin
          cmd_d    = cmd_i;
          second_d = 1'b0;
          st_d     = B_VISIT;
        end
      end
      B_VISIT: begin
        if (hit) begin
          resp_d = '{valid: 1'b1, hit: 1'b1, verdict: V_ON_VERTEX};
          st_d   = B_IDLE;
        end else if (!has_prev || q == prevq_q) begin
          if (!has_prev) wsum_d = '0;
          prev_lat_d = cur_lat;
          prev_lon_d = cur_lon;
          prevq_d    = q;
          st_d       = B_NEXT;
        end else if (q_adj_up || q_adj_dn) begin
          wsum_d     = q_adj_up ? (wsum_q + 32'd1) : (wsum_q - 32'd1);
          prev_lat_d = cur_lat;
          prev_lon_d = cur_lon;
          prevq_d    = q;
          st_d       = B_NEXT;
        end else if (cur_lon == prev_lon_q || cur_lat == prev_lat_q) begin
          resp_d = '{valid: 1'b1, hit: 1'b1, verdict: V_ON_SEGMENT};
          st_d   = B_IDLE;
        end else begin
          // Diagonal jump: prepare operands for the exact crossing test.
          newq_d = q;
          nn_d   = (e_s[33] != dlon_s[33]) ^ dlat_s[33];
          md_d   = 33'(mag34(dlat_s));
          c_d    = {cur_lon[31], cur_lon} - {tn[31], tn};
          idx_d  = 2'd0;
          cnt_d  = '0;
          macc_d = '0;
          ma_d   = {34'd0, mag34(e_s)};
          mb_d   = mag34(dlon_s);
          st_d   = B_MUL;
        end
      end
      B_MUL: begin
        macc_d = macc_nx;
        ma_d   = ma_q << 1;
        mb_d   = mb_q >> 1;
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q == 6'd33) begin
          prod_d[idx_q] = macc_nx;
          if (idx_q == 2'd3) begin
            st_d = B_DIAG;
          end else begin
            idx_d  = idx_q + 2'd1;
            cnt_d  = '0;
            macc_d = '0;
            ma_d   = {34'd0, op_a};
            mb_d   = {1'b0, md_q};
          end
        end
      end
      B_DIAG: begin
        if (eq) begin
          resp_d = '{valid: 1'b1, hit: 1'b1, verdict: V_ON_SEGMENT};
          st_d   = B_IDLE;
        end else begin
          wsum_d     = ((newq_q >= 2'd2) == less) ? (wsum_q + 32'd2) : (wsum_q - 32'd2);
          prev_lat_d = cur_lat;
          prev_lon_d = cur_lon;
          prevq_d    = newq_q;
          st_d       = B_NEXT;
        end
      end
      B_NEXT: begin
        if (!second_q && cmd_q.close) begin
          second_d = 1'b1;
          st_d     = B_VISIT;
        end else begin
          resp_d = '{valid: 1'b1, hit: cmd_q.finish, verdict: final_verdict(wsum_q)};
          st_d   = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    newq_q     <= newq_d;
    nn_q       <= nn_d;
    c_q        <= c_d;
    md_q       <= md_d;
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    macc_q     <= macc_d;
    ma_q       <= ma_d;
    mb_q       <= mb_d;
    prod_q     <= prod_d;
    prev_lat_q <= prev_lat_d;
    prev_lon_q <= prev_lon_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_IDLE;
      second_q <= 1'b0;
      prevq_q  <= 2'd0;
      wsum_q   <= '0;
      resp_q   <= '0;
    end else begin
      st_q     <= st_d;
      second_q <= second_d;
      prevq_q  <= prevq_d;
      wsum_q   <= wsum_d;
      resp_q   <= resp_d;
    end
  end

endmodule

[rtl/polygon_winding_point_test.sv]
// ----------------------------------------------------------------------------
// polygon_winding_point_test: streaming point-in-polygon classifier
// Parses encoded polygon records a byte at a time and classifies a target
// point by quadrant winding number.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one record byte per word, with flags for
// the first byte of a record and for the last byte of the buffer. The output
// channel carries at most one verdict word per record, produced as soon as the
// record is decided; bytes after that are dropped until the next record start.
// The user sets the target point over the write port while the block is idle;
// the block itself does not enforce this. A byte that completes a vertex, or
// a zero vertex count, holds the input while the geometry unit visits the
// point, and the closing point too when it closes the polygon. Each diagonal
// quadrant jump also holds it while the shared shift-add multiplier runs its
// four passes and the crossing test is decided. A verdict from the geometry
// unit becomes valid in the same cycle as the parser is free to take the next
// byte; a parse error found by the parser is valid the cycle after its byte.
// Reset clears the parser, queue and winding unit; the block then waits for a
// record start and both target registers read zero.
// A stalled verdict holds the output register; the next byte is then held
// off until the verdict is taken.
// ----------------------------------------------------------------------------
module polygon_winding_point_test #(
  parameter int unsigned MaxVertices = pwpt_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [pwpt_pkg::CoordW-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          record_start_i,
  input  logic                          buffer_last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pwpt_pkg::VerdictW-1:0] verdict_o
);
  import pwpt_pkg::*;

  logic [CoordW-1:0] target_lat_q, target_lon_q;
  logic              cmd_push, cmd_pop, cmd_avail, cmd_full;
  cmd_t              cmd_in, cmd_head;
  resp_t             resp;
  front_stat_t       fstat;

  // Target registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_lat_q <= '0;
      target_lon_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TARGET_LAT) target_lat_q <= cfg_wdata_i;
      if (cfg_idx_i == REG_TARGET_LON) target_lon_q <= cfg_wdata_i;
    end
  end

  // Front: varint parsing, vertex bookkeeping and the verdict register.
  pwpt_front #(.MaxVertices(MaxVertices)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .data_byte_i, .record_start_i, .buffer_last_i,
    .out_valid_o, .out_stall_i, .verdict_o,
    .cmd_push_o(cmd_push), .cmd_o(cmd_in), .resp_i(resp), .stat_o(fstat)
  );

  // Queue of geometry commands between the two halves.
  pwpt_cmd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i(cmd_push), .push_data_i(cmd_in), .pop_i(cmd_pop),
    .head_o(cmd_head), .not_empty_o(cmd_avail), .full_o(cmd_full)
  );

  // Back: quadrant tracking, winding sum and the diagonal crossing test.
  pwpt_back u_back (
    .clk_i, .rst_ni,
    .target_lat_i(target_lat_q), .target_lon_i(target_lon_q),
    .cmd_avail_i(cmd_avail), .cmd_i(cmd_head), .cmd_pop_o(cmd_pop), .resp_o(resp)
  );

  // The parser has at most one command outstanding, so the queue never fills.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full) else $error("command queue overflow");

  // A geometry reply only comes while the parser waits for one.
  a_resp_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp.valid |-> fstat.busy) else $error("unexpected geometry reply");

  // A byte word is only taken when no command is left in the queue.
  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !cmd_avail) else $error("byte taken with queued work");

  // A verdict word is loaded only from a decided record.
  a_verdict_decided: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> fstat.decided) else $error("verdict from undecided record");

endmodule

[verif/polygon_winding_point_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_winding_point_test_tb: self-checking bench of the winding classifier
// Streams encoded polygon records a byte at a time under random sender gaps
// and receiver stalls, predicts every verdict from the byte stream and checks
// each verdict word against the oldest predicted one, over several targets.
// ----------------------------------------------------------------------------
module polygon_winding_point_test_tb;
  import pwpt_pkg::*;

  // Verdict predictor and scoreboard. It decodes the byte stream the same way
  // the block must and queues the verdict that each accepted word causes.
  class verdict_board;
    bit [31:0] tgt_lat, tgt_lon;
    bit [31:0] accum, vtotal, vdone;
    int unsigned shift;
    phase_e phase;
    bit [31:0] pt_lat, pt_lon, fst_lat, fst_lon, prv_lat, prv_lon, wsum;
    bit [1:0] prv_quad;
    bit decided;
    logic [VerdictW-1:0] verdict_q[$];
    int fails, reported, seen[6];

    function new();
      tgt_lat = 0;
      tgt_lon = 0;
      clear_record();
      decided = 1;
    endfunction

    function void clear_record();
      accum = 0; shift = 0; phase = PH_COUNT; vtotal = 0; vdone = 0;
      pt_lat = 0; pt_lon = 0; fst_lat = 0; fst_lon = 0;
      prv_lat = 0; prv_lon = 0; prv_quad = 0; wsum = 0;
    endfunction

    function longint sx(bit [31:0] v);
      return longint'($signed(v));
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    // Sign of a + b where each term is given as a sign and a magnitude.
    function int sum_sign(bit na, longint unsigned ma, bit nb, longint unsigned mb);
      if (ma == 0 && mb == 0) return 0;
      if (ma == 0) return nb ? -1 : 1;
      if (mb == 0) return na ? -1 : 1;
      if (na == nb) return na ? -1 : 1;
      if (ma == mb) return 0;
      if (ma > mb) return na ? -1 : 1;
      return nb ? -1 : 1;
    endfunction

    function bit [31:0] unzig(bit [31:0] v);
      return v[0] ? 32'd0 - (v >> 1) : (v >> 1);
    endfunction

    // Visits one vertex; returns -1 while the record is still open.
    function int visit(bit [31:0] vlat, bit [31:0] vlon, bit has_prev);
      longint tl, tn, pl, pn, ql, qn, dlat, dlon, c, e;
      longint unsigned mn, md;
      bit [1:0] q;
      bit nn, eq, less;
      int cm1, c0, c1;
      tl = sx(tgt_lat); tn = sx(tgt_lon - 32'd3);
      pl = sx(vlat); pn = sx(vlon); ql = sx(prv_lat); qn = sx(prv_lon);
      if (pl == tl && pn == tn) return V_ON_VERTEX;
      if (pl >= tl) q = (pn >= tn) ? 2'd0 : 2'd1;
      else q = (pn >= tn) ? 2'd3 : 2'd2;
      if (has_prev && q != prv_quad) begin
        if (q == prv_quad + 2'd1) wsum += 1;
        else if (q + 2'd1 == prv_quad) wsum -= 1;
        else begin
          // Diagonal jump: locate the crossing longitude exactly.
          if (pn == qn || pl == ql) return V_ON_SEGMENT;
          dlat = pl - ql; dlon = pn - qn; c = pn - tn; e = tl - pl;
          nn = (e < 0) != (dlon < 0);
          mn = mag(e) * mag(dlon);
          if (dlat < 0) nn = !nn;
          md = mag(dlat);
          cm1 = sum_sign(c + 1 < 0, mag(c + 1) * md, nn, mn);
          c0 = sum_sign(c < 0, mag(c) * md, nn, mn);
          c1 = sum_sign(c - 1 < 0, mag(c - 1) * md, nn, mn);
          if (tn > 0) begin
            eq = c0 >= 0 && c1 < 0; less = c0 < 0;
          end else if (tn == 0) begin
            eq = cm1 > 0 && c1 < 0; less = cm1 <= 0;
          end else begin
            eq = cm1 > 0 && c0 <= 0; less = cm1 <= 0;
          end
          if (eq) return V_ON_SEGMENT;
          if ((q >= 2) == less) wsum += 2;
          else wsum -= 2;
        end
      end
      prv_lat = vlat; prv_lon = vlon; prv_quad = q;
      return -1;
    endfunction

    function int winding_verdict();
      if (wsum == 32'hFFFF_FFFC) return V_IN_ZONE;
      if (wsum == 32'd4) return V_EXCLUDED;
      if (wsum == 32'd0) return V_OUTSIDE;
      return V_ON_SEGMENT;
    endfunction

    // Notes one accepted byte word and queues the verdict it causes, if any.
    function void note_byte(bit [7:0] b, bit rs, bit last);
      bit [31:0] v;
      int r;
      r = -1;
      if (rs) begin
        clear_record();
        decided = 0;
      end
      if (decided) return;
      if (shift < 32) begin
        accum |= 32'(b[6:0]) << shift;
        shift += 7;
      end
      if (!b[7]) begin
        v = accum; accum = 0; shift = 0;
        case (phase)
          PH_COUNT: begin
            if (v > MAX_VERTICES_DEF) r = V_PARSE_ERROR;
            else begin
              vtotal = v;
              if (v == 0) begin
                r = visit(fst_lat, fst_lon, 0);
                if (r < 0) r = winding_verdict();
              end else phase = PH_LAT;
            end
          end
          PH_LAT: begin
            pt_lat += unzig(v);
            phase = PH_LON;
          end
          PH_LON: begin
            pt_lon += unzig(v);
            phase = PH_LAT;
            r = visit(pt_lat, pt_lon, vdone > 0);
            if (r < 0) begin
              if (vdone == 0) begin
                fst_lat = pt_lat; fst_lon = pt_lon;
              end
              vdone++;
              if (vdone >= vtotal) begin
                r = visit(fst_lat, fst_lon, 1);
                if (r < 0) r = winding_verdict();
              end
            end
          end
          default: r = V_PARSE_ERROR;
        endcase
      end
      if (r < 0 && last) r = V_PARSE_ERROR;
      if (r >= 0) begin
        decided = 1;
        verdict_q.push_back(r[VerdictW-1:0]);
      end
    endfunction

    function void check_verdict(logic [VerdictW-1:0] got);
      logic [VerdictW-1:0] want;
      if (got <= V_PARSE_ERROR) seen[got]++;
      if (verdict_q.size() == 0) begin
        fails++;
        if (reported++ < 10) $display("ERROR: verdict %0d with none expected", got);
        return;
      end
      want = verdict_q.pop_front();
      if (got !== want) begin
        fails++;
        if (reported++ < 10) $display("ERROR: verdict expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = REG_TARGET_LAT;
  logic [CoordW-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          data_byte_i = '0;
  logic                record_start_i = 1'b0;
  logic                buffer_last_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [VerdictW-1:0] verdict_o;

  typedef struct {
    bit [7:0] b;
    bit       rs;
    bit       last;
  } byte_word_t;

  verdict_board board = new();
  byte_word_t   word_q[$];
  bit [7:0]     rec_q[$];
  int           stall_pct = 0;
  bit           send_idle = 1'b1;
  int           accepted = 0;

  polygon_winding_point_test u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .record_start_i(record_start_i),
    .buffer_last_i (buffer_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .verdict_o     (verdict_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver stalls at random with a per-phase probability; zero gives a
  // stretch with no stalls at all.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Both monitors sample the values from before the edge, so they see the
  // same handshake that the block sees.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_byte(data_byte_i, record_start_i, buffer_last_i);
      accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) board.check_verdict(verdict_o);
  end

  // Hard limit, far above the slowest legal run.
  initial begin
    #20_000_000;
    $display("polygon_winding_point_test verification failed");
    $display("timeout with %0d verdicts outstanding", board.verdict_q.size());
    $finish;
  end

  // Appends a varint; pad adds redundant continuation groups so that some
  // varints run past bit 31.
  function automatic void push_varint(bit [31:0] v, int pad);
    do begin
      rec_q.push_back({1'b1, v[6:0]});
      v = v >> 7;
    end while (v != 0);
    if (pad == 0) rec_q[rec_q.size()-1][7] = 1'b0;
    else begin
      repeat (pad - 1) rec_q.push_back(8'h80);
      rec_q.push_back(8'h00);
    end
  endfunction

  function automatic bit [31:0] zig(bit [31:0] d);
    return d[31] ? (((32'd0 - d) << 1) | 32'd1) : (d << 1);
  endfunction

  function automatic int pad_pick();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
  endfunction

  // Encodes a polygon given by absolute vertices into rec_q.
  function automatic void encode_polygon(bit [31:0] lat[$], bit [31:0] lon[$]);
    bit [31:0] pl, pn;
    pl = 0; pn = 0;
    push_varint(lat.size(), pad_pick());
    foreach (lat[i]) begin
      push_varint(zig(lat[i] - pl), pad_pick());
      push_varint(zig(lon[i] - pn), pad_pick());
      pl = lat[i]; pn = lon[i];
    end
  endfunction

  // Moves rec_q into the word stream as one record; trunc ends it early with
  // the last flag, cut ends it early so that the next record restarts it.
  function automatic void queue_record(bit trunc, bit cut, int junk);
    int n;
    byte_word_t w;
    n = rec_q.size();
    if ((trunc || cut) && n > 1) n = $urandom_range(1, n - 1);
    for (int i = 0; i < n; i++) begin
      w.b = rec_q[i]; w.rs = (i == 0); w.last = trunc && (i == n - 1);
      word_q.push_back(w);
    end
    repeat (junk) begin
      w.b = $urandom(); w.rs = 1'b0; w.last = ($urandom_range(0, 7) == 0);
      word_q.push_back(w);
    end
    rec_q.delete();
  endfunction

  // Builds one record of a given kind around the current target.
  function automatic void build_record(int kind, longint unsigned r);
    bit [31:0] lat[$], lon[$];
    bit [31:0] tl, tn;
    int n, rot;
    bit rev;
    tl = board.tgt_lat; tn = board.tgt_lon - 32'd3;
    case (kind)
      0: begin
        // Square around the target, either winding direction and start.
        rev = $urandom_range(0, 1);
        rot = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
          int k;
          k = (rev ? 3 - i : i) + rot;
          lat.push_back(tl + ((k % 4) < 2 ? 32'(r) : -32'(r)));
          lon.push_back(tn + ((k % 4) == 0 || (k % 4) == 3 ? 32'(r) : -32'(r)));
        end
        encode_polygon(lat, lon);
      end
      1: begin
        n = $urandom_range(1, 7);
        repeat (n) begin
          lat.push_back(tl + 32'($signed($urandom_range(0, 6)) - 3));
          lon.push_back(tn + 32'($signed($urandom_range(0, 6)) - 3));
        end
        encode_polygon(lat, lon);
      end
      2: begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          lat.push_back($urandom());
          lon.push_back($urandom());
        end
        encode_polygon(lat, lon);
      end
      3: push_varint(0, pad_pick());
      4: begin
        push_varint(32'(r), 0);
        repeat ($urandom_range(0, 6)) rec_q.push_back($urandom());
      end
      default: repeat ($urandom_range(1, 10)) rec_q.push_back($urandom());
    endcase
  endfunction

  function automatic void random_record();
    int k;
    longint unsigned r;
    k = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: r = $urandom_range(1, 3);
      1: r = $urandom_range(1, 1000);
      2: r = $urandom_range(1, 32'h4000_0000);
      default: r = $urandom_range(1, 32'h7FFF_FFFF);
    endcase
    if (k < 35) build_record(0, r);
    else if (k < 70) build_record(1, 0);
    else if (k < 85) build_record(2, 0);
    else if (k < 89) build_record(3, 0);
    else if (k < 93) build_record(4, $urandom_range(MAX_VERTICES_DEF + 1, 32'hFFFF_FFFF));
    else build_record(5, 0);
    queue_record($urandom_range(0, 9) == 0, $urandom_range(0, 19) == 0,
                 ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
  endfunction

  // Sends the queued words in bursts with random gaps between them when send_idle is set.
  task automatic send_words();
    int burst;
    burst = $urandom_range(1, 12);
    while (word_q.size() != 0) begin
      byte_word_t w;
      w = word_q.pop_front();
      in_valid_i     <= 1'b1;
      data_byte_i    <= w.b;
      record_start_i <= w.rs;
      buffer_last_i  <= w.last;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      if (send_idle && --burst == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst = $urandom_range(1, 12);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // Lets every outstanding verdict arrive, then allows for a diagonal step
  // that may still be in flight behind a byte that causes no verdict.
  task automatic settle();
    while (board.verdict_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // One register write; the enable drops before the next write may start.
  task automatic write_target(logic idx, bit [31:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TARGET_LAT) board.tgt_lat = value;
    else board.tgt_lon = value;
    @(posedge clk_i);
  endtask

  initial begin
    bit [31:0] tgt_list[8][2];
    tgt_list = '{'{32'd0, 32'd0}, '{32'd0, 32'd3},
                 '{32'h7FFF_FFFF, 32'h7FFF_FFFF}, '{32'h8000_0000, 32'h8000_0000},
                 '{32'h8000_0000, 32'h8000_0002}, '{32'd5, 32'd2},
                 '{$urandom(), $urandom()}, '{$urandom(), $urandom()}};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset target: two randomly oriented squares, a vertex
    // hit, a segment through the target, an empty polygon, an oversized
    // count, an exact maximum count that gets truncated, a restart, long
    // varints and stray bytes while no record is open.
    build_record(0, 1);  queue_record(0, 0, 0);
    build_record(0, 32'h4000_0000); queue_record(0, 0, 2);
    push_varint(3, 0); push_varint(zig(32'd0), 0); push_varint(zig(-32'd3), 0);
    push_varint(zig(32'd4), 0); push_varint(zig(32'd4), 0);
    push_varint(zig(-32'd4), 0); push_varint(zig(32'd0), 0);
    queue_record(0, 0, 0);
    push_varint(3, 0); push_varint(zig(32'd0), 0); push_varint(zig(-32'd5), 0);
    push_varint(zig(32'd0), 0); push_varint(zig(32'd4), 0);
    push_varint(zig(32'd5), 0); push_varint(zig(32'd0), 0);
    queue_record(0, 0, 0);
    build_record(3, 0);  queue_record(0, 0, 0);
    build_record(4, MAX_VERTICES_DEF + 1); queue_record(0, 0, 0);
    push_varint(MAX_VERTICES_DEF, 0); push_varint(zig(32'd7), 0);
    queue_record(1, 0, 0);
    build_record(1, 0);  queue_record(0, 1, 0);
    push_varint(1, 5); push_varint(32'hFFFF_FFFF, 3); push_varint(zig(-32'd3), 0);
    queue_record(0, 0, 3);
    build_record(2, 0);  queue_record(0, 0, 0);
    send_words();
    settle();

    foreach (tgt_list[p]) begin
      write_target(REG_TARGET_LAT, tgt_list[p][0]);
      write_target(REG_TARGET_LON, tgt_list[p][1]);
      stall_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 30 : 75;
      send_idle = (p % 4 != 2);
      build_record(3, 0); queue_record(0, 0, 0);
      while (word_q.size() < 75) random_record();
      send_words();
      settle();
    end

    $display("Summary: %0d byte words accepted over %0d target settings.",
             accepted, $size(tgt_list) + 1);
    $display("Verdicts seen: outside %0d, in zone %0d, excluded %0d, vertex %0d, %s %0d, %s %0d",
             board.seen[V_OUTSIDE], board.seen[V_IN_ZONE], board.seen[V_EXCLUDED],
             board.seen[V_ON_VERTEX], "segment", board.seen[V_ON_SEGMENT],
             "parse error", board.seen[V_PARSE_ERROR]);
    if (board.fails == 0 && board.verdict_q.size() == 0) begin
      $display("polygon_winding_point_test verification clean");
    end else begin
      $display("%0d mismatches, %0d verdicts never arrived",
               board.fails, board.verdict_q.size());
      $display("polygon_winding_point_test verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/pwpt_pkg.sv
rtl/pwpt_cmd_fifo.sv
rtl/pwpt_front.sv
rtl/pwpt_back.sv
rtl/polygon_winding_point_test.sv
verif/polygon_winding_point_test_tb.sv
